/* hw/rtl/conv3x3_line_buffer_filter_macros.svh */
// Assertion macros for the 3x3 line buffer filter.
`ifndef CONV3X3_LINE_BUFFER_FILTER_MACROS_SVH
`define CONV3X3_LINE_BUFFER_FILTER_MACROS_SVH
`ifndef SYNTH
// same-cycle implication, sampled on clk, off while rst_n is low
`define C3LB_ASSERT_IMP(label, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("c3lb: implication check failed");
// next-cycle implication
`define C3LB_ASSERT_NXT(label, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("c3lb: next-cycle check failed");
`else
`define C3LB_ASSERT_IMP(label, a, b)
`define C3LB_ASSERT_NXT(label, a, b)
`endif
`endif

/* hw/rtl/c3lb_pkg.sv */
// Shared constants, register codes and queue entry types of the 3x3 line buffer filter.
package c3lb_pkg;

    localparam int PIX_W          = 8;
    localparam int OUT_W          = 20;
    localparam int CAP_HIGH       = 255;
    localparam int TAPS           = 3;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;
    localparam int DEF_COEF_BITS  = 8;

    localparam int RST_FRAME_WIDTH  = 640;
    localparam int RST_FRAME_HEIGHT = 480;
    localparam int MIN_DIM          = 3;
    // reset coefficient rows: top {0,1,0}, mid {1,-4,0}, bot {1,0,0}
    localparam logic [63:0] RST_COEF_TOP = 64'd256;
    localparam logic [63:0] RST_COEF_MID = 64'd64513;
    localparam logic [63:0] RST_COEF_BOT = 64'd1;

    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH  = 3'd0,
        REG_FRAME_HEIGHT = 3'd1,
        REG_COEF_TOP     = 3'd2,
        REG_COEF_MID     = 3'd3,
        REG_COEF_BOT     = 3'd4
    } c3lb_reg_t;

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;
    localparam int Q_CNT_W = 3;

    typedef struct packed {
        logic produce;   // interior pixel: a result follows
        logic last;      // final interior pixel of the frame
    } c3lb_tag_t;

    typedef struct packed {
        logic [PIX_W-1:0] top;
        logic [PIX_W-1:0] mid;
        logic [PIX_W-1:0] bot;
        c3lb_tag_t        tag;
    } c3lb_entry_t;

endpackage

/* hw/rtl/conv3x3_line_buffer_filter.sv */
// Top level of the 3x3 line buffer filter: configuration registers, front, queue and back.
`include "conv3x3_line_buffer_filter_macros.svh"

// Streams 8-bit pixels of a frame in raster order, one item per clock sustained while
// the output is not stalled, and gives one result per interior pixel (the one-pixel
// border gives none): the negated 3x3 weighted sum capped above at 255, a
// differs-from-centre flag, and on the final interior result a last flag with the
// frame-changed flag. A pixel's result passes the line store read register, the
// column queue, then the window, product, row sum and output stages. in_ready falls
// only when the four-entry column queue has no room for both the item in flight and
// a new one; a stalled output holds the back end, and the front keeps taking pixels
// until the queue fills. The line stores need no clearing after reset. Write the
// registers only while the block is idle; a geometry write restarts the frame.
module conv3x3_line_buffer_filter #(
    parameter int MAX_WIDTH  = c3lb_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = c3lb_pkg::DEF_MAX_HEIGHT,
    parameter int COEF_BITS  = c3lb_pkg::DEF_COEF_BITS,
    localparam int CW    = 3 * COEF_BITS,
    localparam int CFG_W = (CW > 11) ? CW : 11
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [c3lb_pkg::PIX_W-1:0]          pixel,
    input  logic                                in_valid,
    output logic                                in_ready,
    output logic signed [c3lb_pkg::OUT_W-1:0]   filtered,
    output logic                                differs,
    output logic                                frame_changed,
    output logic                                last,
    output logic                                out_valid,
    input  logic                                out_ready,
    input  logic                                cfg_we,
    input  logic [c3lb_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [CFG_W-1:0]                    cfg_data
);
    import c3lb_pkg::*;

    localparam int DW = $clog2(MAX_WIDTH + 1);
    localparam int DH = $clog2(MAX_HEIGHT + 1);
    localparam int W_RST = (RST_FRAME_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RST_FRAME_WIDTH;
    localparam int H_RST = (RST_FRAME_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT : RST_FRAME_HEIGHT;

    logic [DW-1:0] frame_width_reg;
    logic [DH-1:0] frame_height_reg;
    logic [CW-1:0] coef_top_reg;
    logic [CW-1:0] coef_mid_reg;
    logic [CW-1:0] coef_bot_reg;

    logic [63:0]   data_ext;
    logic [DW-1:0] width_clamped;
    logic [DH-1:0] height_clamped;
    logic          restart;

    logic               q_push;
    logic               q_pop;
    logic               q_valid;
    logic [Q_CNT_W-1:0] q_count;
    c3lb_entry_t        q_in_entry;
    c3lb_entry_t        q_out_entry;

    always_comb
    begin
        data_ext       = 64'(cfg_data);
        width_clamped  = (data_ext < 64'(MIN_DIM))   ? DW'(MIN_DIM)   :
                         (data_ext > 64'(MAX_WIDTH)) ? DW'(MAX_WIDTH) : DW'(data_ext);
        height_clamped = (data_ext < 64'(MIN_DIM))    ? DH'(MIN_DIM)    :
                         (data_ext > 64'(MAX_HEIGHT)) ? DH'(MAX_HEIGHT) : DH'(data_ext);
        restart        = cfg_we && ((cfg_index == REG_FRAME_WIDTH)
                                    || (cfg_index == REG_FRAME_HEIGHT));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= DW'(W_RST);
            frame_height_reg <= DH'(H_RST);
            coef_top_reg     <= CW'(RST_COEF_TOP);
            coef_mid_reg     <= CW'(RST_COEF_MID);
            coef_bot_reg     <= CW'(RST_COEF_BOT);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_FRAME_WIDTH:  frame_width_reg  <= width_clamped;
                REG_FRAME_HEIGHT: frame_height_reg <= height_clamped;
                REG_COEF_TOP:     coef_top_reg     <= cfg_data[CW-1:0];
                REG_COEF_MID:     coef_mid_reg     <= cfg_data[CW-1:0];
                REG_COEF_BOT:     coef_bot_reg     <= cfg_data[CW-1:0];
                default:          ;
            endcase
        end
    end

    c3lb_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .pixel        (pixel),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .frame_width  (frame_width_reg),
        .frame_height (frame_height_reg),
        .restart      (restart),
        .q_count      (q_count),
        .push         (q_push),
        .push_entry   (q_in_entry)
    );

    c3lb_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_in_entry),
        .pop        (q_pop),
        .pop_entry  (q_out_entry),
        .q_valid    (q_valid),
        .count      (q_count)
    );

    c3lb_back #(
        .COEF_BITS (COEF_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .coef_top      (coef_top_reg),
        .coef_mid      (coef_mid_reg),
        .coef_bot      (coef_bot_reg),
        .restart       (restart),
        .q_valid       (q_valid),
        .q_entry       (q_out_entry),
        .pop           (q_pop),
        .filtered      (filtered),
        .differs       (differs),
        .frame_changed (frame_changed),
        .last          (last),
        .out_valid     (out_valid),
        .out_ready     (out_ready)
    );

    // the queue takes an entry while full only when one leaves in the same cycle
    `C3LB_ASSERT_IMP(a_queue_no_overflow, q_push && (q_count == Q_CNT_W'(Q_DEPTH)), q_pop)
    // filling the last free slot closes the intake
    `C3LB_ASSERT_NXT(a_intake_closes, q_push && !q_pop && (q_count == Q_CNT_W'(Q_DEPTH - 1)), !in_ready)
    // frame flag only rides on the final result
    `C3LB_ASSERT_IMP(a_changed_on_last, out_valid && frame_changed, last)
    // a result equal to its centre pixel lies in 0..255
    `C3LB_ASSERT_IMP(a_same_is_pixel, out_valid && !differs, filtered[OUT_W-1:PIX_W] == '0)

endmodule

/* hw/rtl/c3lb_front.sv */
// Front end: pixel intake, raster counters, two line stores, window column to the queue.
module c3lb_front #(
    parameter int MAX_WIDTH  = c3lb_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = c3lb_pkg::DEF_MAX_HEIGHT,
    localparam int DW = $clog2(MAX_WIDTH + 1),
    localparam int DH = $clog2(MAX_HEIGHT + 1)
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [c3lb_pkg::PIX_W-1:0]   pixel,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [DW-1:0]                frame_width,
    input  logic [DH-1:0]                frame_height,
    input  logic                         restart,
    input  logic [c3lb_pkg::Q_CNT_W-1:0] q_count,
    output logic                         push,
    output c3lb_pkg::c3lb_entry_t        push_entry
);
    import c3lb_pkg::*;

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);

    logic [PIX_W-1:0] mem_a [MAX_WIDTH];
    logic [PIX_W-1:0] mem_b [MAX_WIDTH];

    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic             s1_valid_reg;
    logic [COL_W-1:0] col_s1_reg;
    logic [PIX_W-1:0] px_s1_reg;
    c3lb_tag_t        tag_s1_reg;
    logic [PIX_W-1:0] rd_a_reg;
    logic [PIX_W-1:0] rd_b_reg;

    logic      accept;
    logic      col_end;
    logic      row_end;
    c3lb_tag_t tag;

    // room for the item in flight plus this one
    assign in_ready = ({1'b0, q_count} + {{Q_CNT_W{1'b0}}, s1_valid_reg})
                      < (Q_CNT_W + 1)'(Q_DEPTH);
    assign accept   = in_valid && in_ready;

    assign col_end     = (DW'(col_reg) + DW'(1)) == frame_width;
    assign row_end     = (DH'(row_reg) + DH'(1)) == frame_height;
    assign tag.produce = (row_reg >= ROW_W'(2)) && (col_reg >= COL_W'(2));
    assign tag.last    = col_end && row_end;

    always_comb
    begin
        col_next = col_reg + COL_W'(1);
        row_next = row_reg;
        if (col_end)
        begin
            col_next = '0;
            row_next = row_end ? '0 : row_reg + ROW_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            if (restart)
            begin
                col_reg <= '0;
                row_reg <= '0;
            end
            else if (accept)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            col_s1_reg <= col_reg;
            px_s1_reg  <= pixel;
            tag_s1_reg <= tag;
        end
    end

    // store a: read old row, write current pixel at the same column
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_a_reg       <= mem_a[col_reg];
            mem_a[col_reg] <= pixel;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_b_reg <= mem_b[col_reg];
        end
    end

    // store b takes the row leaving store a, from the store a read register in the next cycle
    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            mem_b[col_s1_reg] <= rd_a_reg;
        end
    end

    assign push           = s1_valid_reg;
    assign push_entry.top = rd_b_reg;
    assign push_entry.mid = rd_a_reg;
    assign push_entry.bot = px_s1_reg;
    assign push_entry.tag = tag_s1_reg;

endmodule

/* hw/rtl/c3lb_queue.sv */
// Short FIFO of window columns between front and back.
module c3lb_queue (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    input  c3lb_pkg::c3lb_entry_t        push_entry,
    input  logic                         pop,
    output c3lb_pkg::c3lb_entry_t        pop_entry,
    output logic                         q_valid,
    output logic [c3lb_pkg::Q_CNT_W-1:0] count
);
    import c3lb_pkg::*;

    c3lb_entry_t        slot_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg;
    logic [Q_PTR_W-1:0] rd_ptr_reg;
    logic [Q_CNT_W-1:0] count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + Q_PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + Q_PTR_W'(1);
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + Q_CNT_W'(1);
                2'b01:   count_reg <= count_reg - Q_CNT_W'(1);
                default: count_reg <= count_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    assign pop_entry = slot_reg[rd_ptr_reg];
    assign q_valid   = count_reg != '0;
    assign count     = count_reg;

endmodule

/* hw/rtl/c3lb_back.sv */
// Back end: 3x3 window, products, row sums, negate and cap, output register.
module c3lb_back #(
    parameter int COEF_BITS = c3lb_pkg::DEF_COEF_BITS,
    localparam int CW = 3 * COEF_BITS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [CW-1:0]                     coef_top,
    input  logic [CW-1:0]                     coef_mid,
    input  logic [CW-1:0]                     coef_bot,
    input  logic                              restart,
    input  logic                              q_valid,
    input  c3lb_pkg::c3lb_entry_t             q_entry,
    output logic                              pop,
    output logic signed [c3lb_pkg::OUT_W-1:0] filtered,
    output logic                              differs,
    output logic                              frame_changed,
    output logic                              last,
    output logic                              out_valid,
    input  logic                              out_ready
);
    import c3lb_pkg::*;

    localparam int PROD_W = PIX_W + 1 + COEF_BITS;
    localparam int RS_W   = PROD_W + 2;
    localparam int SUM_W  = PROD_W + 4;
    localparam int ACC_W  = (SUM_W > OUT_W) ? SUM_W : OUT_W;

    logic [PIX_W-1:0]         win_reg  [TAPS][TAPS];
    logic [CW-1:0]            coef_row [TAPS];
    logic signed [COEF_BITS-1:0] coef  [TAPS][TAPS];
    logic signed [PROD_W-1:0] prod_next [TAPS][TAPS];
    logic signed [PROD_W-1:0] prod_reg  [TAPS][TAPS];
    logic signed [RS_W-1:0]   rsum_reg  [TAPS];

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic last1_reg, last2_reg, last3_reg;
    logic [PIX_W-1:0] center2_reg, center3_reg;
    logic any_changed_reg;
    logic signed [OUT_W-1:0] filtered_reg;
    logic differs_reg, frame_changed_reg, last_reg;

    logic free1, free2, free3, free4;
    logic signed [ACC_W-1:0] neg_sum;
    logic signed [ACC_W-1:0] capped;
    logic signed [ACC_W-1:0] center_ext;
    logic diff;
    logic any_next;

    // a stage loads when empty or when its item moves on
    assign free4 = !v4_reg || out_ready;
    assign free3 = !v3_reg || free4;
    assign free2 = !v2_reg || free3;
    assign free1 = !v1_reg || free2;
    assign pop   = q_valid && free1;

    assign coef_row[0] = coef_top;
    assign coef_row[1] = coef_mid;
    assign coef_row[2] = coef_bot;

    always_comb
    begin
        for (int i = 0; i < TAPS; i++)
        begin
            for (int j = 0; j < TAPS; j++)
            begin
                coef[i][j]      = $signed(coef_row[i][j*COEF_BITS +: COEF_BITS]);
                prod_next[i][j] = PROD_W'($signed({1'b0, win_reg[i][j]}))
                                  * PROD_W'(coef[i][j]);
            end
        end
    end

    always_comb
    begin
        neg_sum    = -(ACC_W'(rsum_reg[0]) + ACC_W'(rsum_reg[1]) + ACC_W'(rsum_reg[2]));
        capped     = (neg_sum > ACC_W'(CAP_HIGH)) ? ACC_W'(CAP_HIGH) : neg_sum;
        center_ext = $signed(ACC_W'({1'b0, center3_reg}));
        diff       = capped != center_ext;
        any_next   = any_changed_reg || diff;
    end

    // window shifts on every item, border pixels included
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TAPS; i++)
            begin
                for (int j = 0; j < TAPS; j++)
                begin
                    win_reg[i][j] <= '0;
                end
            end
        end
        else if (pop)
        begin
            for (int i = 0; i < TAPS; i++)
            begin
                win_reg[i][0] <= win_reg[i][1];
                win_reg[i][1] <= win_reg[i][2];
            end
            win_reg[0][2] <= q_entry.top;
            win_reg[1][2] <= q_entry.mid;
            win_reg[2][2] <= q_entry.bot;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg          <= 1'b0;
            v2_reg          <= 1'b0;
            v3_reg          <= 1'b0;
            v4_reg          <= 1'b0;
            any_changed_reg <= 1'b0;
        end
        else
        begin
            if (free1)
            begin
                v1_reg <= pop && q_entry.tag.produce;
            end
            if (free2)
            begin
                v2_reg <= v1_reg;
            end
            if (free3)
            begin
                v3_reg <= v2_reg;
            end
            if (free4)
            begin
                v4_reg <= v3_reg;
            end
            if (restart)
            begin
                any_changed_reg <= 1'b0;
            end
            else if (free4 && v3_reg)
            begin
                any_changed_reg <= last3_reg ? 1'b0 : any_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            last1_reg <= q_entry.tag.last;
        end
        if (free2 && v1_reg)
        begin
            prod_reg    <= prod_next;
            center2_reg <= win_reg[1][1];
            last2_reg   <= last1_reg;
        end
        if (free3 && v2_reg)
        begin
            for (int i = 0; i < TAPS; i++)
            begin
                rsum_reg[i] <= RS_W'(prod_reg[i][0]) + RS_W'(prod_reg[i][1])
                               + RS_W'(prod_reg[i][2]);
            end
            center3_reg <= center2_reg;
            last3_reg   <= last2_reg;
        end
        if (free4 && v3_reg)
        begin
            filtered_reg      <= capped[OUT_W-1:0];
            differs_reg       <= diff;
            frame_changed_reg <= last3_reg && any_next;
            last_reg          <= last3_reg;
        end
    end

    assign filtered      = filtered_reg;
    assign differs       = differs_reg;
    assign frame_changed = frame_changed_reg;
    assign last          = last_reg;
    assign out_valid     = v4_reg;

endmodule
